// ===== rtl/occ_pkg.sv =====
// occ_pkg: shared types and constants of the occupancy timeout tracker.
// Used by occ_cfg, occ_core and occupancy_timeout_fsm; depends on nothing.
package occ_pkg;

	localparam int TS_W     = 48;
	localparam int SEC_W    = 16;
	localparam int HOUR_W   = 5;
	localparam int NG_W     = 5;
	localparam int MS_PER_S = 1000;
	localparam int TMS_W    = 26;
	localparam int FIDX_W   = 4;

	localparam logic [2:0] CMD_SAMPLE     = 3'd0;
	localparam logic [2:0] CMD_TICK       = 3'd1;
	localparam logic [2:0] CMD_DOOR_OPEN  = 3'd2;
	localparam logic [2:0] CMD_DOOR_CLOSE = 3'd3;
	localparam logic [2:0] CMD_ACTION     = 3'd4;

	localparam logic [2:0] REG_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_DAY     = 3'd1;
	localparam logic [2:0] REG_NIGHT   = 3'd2;
	localparam logic [2:0] REG_ALIVE   = 3'd3;
	localparam logic [2:0] REG_GROUPS  = 3'd4;

	localparam logic [1:0] STC_IDLE      = 2'd0;
	localparam logic [1:0] STC_ACTIVE    = 2'd1;
	localparam logic [1:0] STC_UNCERTAIN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'b001,
		ST_ACTIVE    = 3'b010,
		ST_UNCERTAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic [SEC_W-1:0]  timeout_seconds;
		logic [TMS_W-1:0]  timeout_ms;
		logic [HOUR_W-1:0] day_start_hour;
		logic [HOUR_W-1:0] night_start_hour;
		logic              alive_channel;
		logic [NG_W-1:0]   num_groups;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic              presence;
		logic [TS_W-1:0]   now_ms;
		logic [HOUR_W-1:0] hour_of_day;
		logic              clock_valid;
		logic              any_key_taken;
	} item_t;

	typedef struct packed {
		logic [1:0]        sensor_state_out;
		logic              fire_group;
		logic [FIDX_W-1:0] fired_index;
		logic              fire_timeout;
		logic              timer_running;
	} result_t;

	typedef struct packed {
		state_t state;
		logic   armed;
	} status_t;

endpackage

// ===== rtl/occ_cfg.sv =====
// occ_cfg: APB register file of the occupancy timeout tracker.
// Depends on occ_pkg; keeps the timeout also in milliseconds.
module occ_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output occ_pkg::cfg_t       cfg
);

	logic       wr;
	logic [2:0] idx;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.timeout_seconds  <= 16'd60;
			cfg.timeout_ms       <= 26'd60000;
			cfg.day_start_hour   <= 5'd7;
			cfg.night_start_hour <= 5'd22;
			cfg.alive_channel    <= 1'b0;
			cfg.num_groups       <= 5'd0;
		end else if (wr) begin
			case (idx)
				occ_pkg::REG_TIMEOUT: begin
					cfg.timeout_seconds <= pwdata[15:0];
					cfg.timeout_ms <= occ_pkg::TMS_W'({10'd0, pwdata[15:0]}
						* 26'(occ_pkg::MS_PER_S));
				end
				occ_pkg::REG_DAY:    cfg.day_start_hour   <= pwdata[4:0];
				occ_pkg::REG_NIGHT:  cfg.night_start_hour <= pwdata[4:0];
				occ_pkg::REG_ALIVE:  cfg.alive_channel    <= pwdata[0];
				occ_pkg::REG_GROUPS: cfg.num_groups       <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			occ_pkg::REG_TIMEOUT: prdata = {16'd0, cfg.timeout_seconds};
			occ_pkg::REG_DAY:     prdata = {27'd0, cfg.day_start_hour};
			occ_pkg::REG_NIGHT:   prdata = {27'd0, cfg.night_start_hour};
			occ_pkg::REG_ALIVE:   prdata = {31'd0, cfg.alive_channel};
			occ_pkg::REG_GROUPS:  prdata = {27'd0, cfg.num_groups};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/occ_core.sv =====
// occ_core: tracker state and the single-pass next-state and result logic.
// Depends on occ_pkg; steps once per word when step is high.
module occ_core #(
	parameter int MAX_GROUPS    = 16,
	parameter int IDLE_GUARD_MS = 10000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  occ_pkg::item_t   item,
	input  occ_pkg::cfg_t    cfg,
	output occ_pkg::result_t res,
	output occ_pkg::status_t status
);

	localparam int NMAX = (MAX_GROUPS < 31) ? MAX_GROUPS : 31;
	localparam int GIW  = (NMAX > 1) ? $clog2(NMAX) : 1;
	localparam int TW   = occ_pkg::TS_W;

	occ_pkg::state_t state_q, state_d;
	logic [GIW-1:0]  gidx_q, gidx_d;
	logic            armed_q, armed_d;
	logic [TW-1:0]   deadline_q, deadline_d;
	logic [TW-1:0]   last_pres_q, last_pres_d;
	logic [TW-1:0]   last_close_q, last_close_d;
	logic            door_is_open_q, door_is_open_d;
	logic [TW-1:0]   last_action_q, last_action_d;

	logic                    is_day;
	logic [occ_pkg::TMS_W:0] dur;
	logic [TW:0]             sum;
	logic [TW-1:0]           arm_deadline;
	logic [4:0]              n_groups;
	logic [4:0]              gidx_ext;
	logic [31:0]             gidx_wide;
	logic [TW-1:0]           idle_ms;
	logic                    expire;
	logic                    fire_g, fire_t;
	logic [1:0]              st_code;

	always_comb begin
		if (cfg.day_start_hour < cfg.night_start_hour)
			is_day = (item.hour_of_day >= cfg.day_start_hour) &&
				(item.hour_of_day < cfg.night_start_hour);
		else
			is_day = (item.hour_of_day >= cfg.day_start_hour) ||
				(item.hour_of_day < cfg.night_start_hour);
	end

	assign dur = (item.clock_valid && !is_day) ? {cfg.timeout_ms, 1'b0}
		: {1'b0, cfg.timeout_ms};
	assign sum = {1'b0, item.now_ms} + (TW+1)'(dur);
	assign arm_deadline = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

	assign n_groups  = (32'(cfg.num_groups) < MAX_GROUPS) ? cfg.num_groups
		: 5'(MAX_GROUPS);
	assign gidx_ext  = 5'(gidx_q);
	assign gidx_wide = 32'(gidx_q);
	assign idle_ms   = item.now_ms - last_action_q;
	assign expire    = armed_q && (item.now_ms >= deadline_q);

	always_comb begin
		state_d        = state_q;
		gidx_d         = gidx_q;
		armed_d        = armed_q;
		deadline_d     = deadline_q;
		last_pres_d    = last_pres_q;
		last_close_d   = last_close_q;
		door_is_open_d = door_is_open_q;
		last_action_d  = last_action_q;
		fire_g         = 1'b0;
		fire_t         = 1'b0;
		case (item.cmd)
			occ_pkg::CMD_SAMPLE: begin
				case (state_q)
					occ_pkg::ST_IDLE: begin
						if (item.presence) begin
							state_d     = occ_pkg::ST_ACTIVE;
							last_pres_d = item.now_ms;
							if (!item.any_key_taken && gidx_ext < n_groups) begin
								fire_g = 1'b1;
								gidx_d = (gidx_ext + 5'd1 == n_groups) ? '0
									: gidx_q + GIW'(1);
							end
						end else begin
							state_d    = occ_pkg::ST_UNCERTAIN;
							armed_d    = 1'b1;
							deadline_d = arm_deadline;
						end
					end
					occ_pkg::ST_ACTIVE: begin
						if (!item.presence) begin
							state_d    = occ_pkg::ST_UNCERTAIN;
							armed_d    = 1'b1;
							deadline_d = arm_deadline;
						end
					end
					default: begin
						if (item.presence) begin
							state_d     = occ_pkg::ST_ACTIVE;
							last_pres_d = item.now_ms;
							armed_d     = 1'b0;
						end
					end
				endcase
			end
			occ_pkg::CMD_TICK: begin
				if (expire) begin
					armed_d = 1'b0;
					if (state_q == occ_pkg::ST_UNCERTAIN) begin
						if (!cfg.alive_channel) begin
							state_d = occ_pkg::ST_IDLE;
							fire_t  = 1'b1;
						end else if (door_is_open_q) begin
							armed_d    = 1'b1;
							deadline_d = arm_deadline;
						end else if (!(last_close_q > last_pres_q)) begin
							state_d = occ_pkg::ST_IDLE;
						end else if (idle_ms < TW'(IDLE_GUARD_MS)) begin
							armed_d    = 1'b1;
							deadline_d = arm_deadline;
						end else begin
							state_d = occ_pkg::ST_IDLE;
							fire_t  = 1'b1;
						end
					end
				end
			end
			occ_pkg::CMD_DOOR_OPEN:  door_is_open_d = 1'b1;
			occ_pkg::CMD_DOOR_CLOSE: begin
				door_is_open_d = 1'b0;
				last_close_d   = item.now_ms;
			end
			occ_pkg::CMD_ACTION: last_action_d = item.now_ms;
			default: ;
		endcase
	end

	always_comb begin
		case (state_d)
			occ_pkg::ST_ACTIVE:    st_code = occ_pkg::STC_ACTIVE;
			occ_pkg::ST_UNCERTAIN: st_code = occ_pkg::STC_UNCERTAIN;
			default:               st_code = occ_pkg::STC_IDLE;
		endcase
	end

	assign res.sensor_state_out = st_code;
	assign res.fire_group       = fire_g;
	assign res.fired_index      = fire_g ? gidx_wide[3:0] : '0;
	assign res.fire_timeout     = fire_t;
	assign res.timer_running    = armed_d;

	assign status.state = state_q;
	assign status.armed = armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= occ_pkg::ST_IDLE;
			gidx_q         <= '0;
			armed_q        <= 1'b0;
			deadline_q     <= '0;
			last_pres_q    <= '0;
			last_close_q   <= '0;
			door_is_open_q <= 1'b0;
			last_action_q  <= '0;
		end else if (step) begin
			state_q        <= state_d;
			gidx_q         <= gidx_d;
			armed_q        <= armed_d;
			deadline_q     <= deadline_d;
			last_pres_q    <= last_pres_d;
			last_close_q   <= last_close_d;
			door_is_open_q <= door_is_open_d;
			last_action_q  <= last_action_d;
		end
	end

endmodule

// ===== rtl/occupancy_timeout_fsm.sv =====
// occupancy_timeout_fsm: top level of the infrared occupancy tracker.
// Depends on occ_pkg, occ_cfg and occ_core; holds the input and result registers.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tdata (56b), s_tuser (cmd, 3b)
//   m_*       out   m_tvalid / m_tready    m_tdata (16b)
//   apb       in    psel&penable, pready=1 paddr (5b), pwdata / prdata (32b)
//
// One word per cycle while the output is not stalled; a word waits in the input register and its
// result is written to the output register when it leaves.
// A stalled output holds the result and the input register; a new word is still
// taken while the input register is empty or moving on.
// arst_n clears tracker state, config and valid flags to defaults at once; no clearing pass.
module occupancy_timeout_fsm #(
	parameter int MAX_GROUPS    = 16,
	parameter int IDLE_GUARD_MS = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// presence[0], now_ms[48:1], hour_of_day[53:49], clock_valid[54],
	// any_key_taken[55]
	input  logic [55:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sensor_state_out[1:0], fire_group[2], fired_index[6:3], fire_timeout[7],
	// timer_running[8], zero[15:9]
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	occ_pkg::cfg_t    cfg;
	occ_pkg::item_t   item_s1;
	occ_pkg::result_t res;
	occ_pkg::result_t res_q;
	occ_pkg::status_t status;
	logic             valid_s1;
	logic             m_valid_q;
	logic             adv;
	logic             take;

	assign pready   = 1'b1;
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	occ_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	occ_core #(
		.MAX_GROUPS    (MAX_GROUPS),
		.IDLE_GUARD_MS (IDLE_GUARD_MS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd           <= s_tuser;
			item_s1.presence      <= s_tdata[0];
			item_s1.now_ms        <= s_tdata[48:1];
			item_s1.hour_of_day   <= s_tdata[53:49];
			item_s1.clock_valid   <= s_tdata[54];
			item_s1.any_key_taken <= s_tdata[55];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, res_q.timer_running, res_q.fire_timeout, res_q.fired_index,
		res_q.fire_group, res_q.sensor_state_out};

	a_armed_uncertain: assert property (@(posedge clk) disable iff (!arst_n)
		status.armed == (status.state == occ_pkg::ST_UNCERTAIN))
		else $error("deadline armed out of step with uncertain state");

	a_group_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == occ_pkg::STC_ACTIVE)
		else $error("group fired without active state");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[1:0] == occ_pkg::STC_IDLE && !m_tdata[8])
		else $error("timeout signalled without going idle");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled word");

endmodule
